// ===== rtl/fsps_pkg.sv =====
// Shared types and constants for the file sync poll scheduler.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package fsps_pkg;

  localparam int MAX_FILES = 32;
  localparam int IDX_W     = 5;   // file index
  localparam int DIR_W     = 6;   // directory size, holds MAX_FILES itself
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FILES_IN_USE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_PERIOD = 1'd1;

  localparam logic [DIR_W-1:0]  FILES_RST   = 6'd32;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000000;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_RD_END = 3'd2,
    CMD_WR_END = 3'd3,
    CMD_IDLE   = 3'd4,
    CMD_TICK   = 3'd5,
    CMD_START  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } act_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic walk_step;
    logic sweep_step;
    logic load_out;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic busy;
    logic walk_last;
    logic sweep_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/fsps_ctrl.sv =====
// Controller state machine of the file sync poll scheduler.
// Depends on fsps_pkg; drives the datapath through ctl_t, watches sts_t.
`timescale 1ns / 1ps
`default_nettype none

module fsps_ctrl
  import fsps_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SWEEP,
    S_POST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctl.latch_in   = (state_r == S_IDLE) && in_valid;
    ctl.exec       = (state_r == S_DECODE);
    ctl.walk_step  = (state_r == S_WALK);
    ctl.sweep_step = (state_r == S_SWEEP);
    ctl.load_out   = (state_r == S_POST) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_IDLE:            state_nxt = sts.busy ? S_POST : S_WALK;
          CMD_TICK, CMD_START: state_nxt = S_SWEEP;
          default:             state_nxt = S_POST;
        endcase
      end
      S_WALK: begin
        if (sts.walk_last) state_nxt = S_POST;
      end
      S_SWEEP: begin
        if (sts.sweep_last) state_nxt = S_POST;
      end
      S_POST: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fsps_dp.sv =====
// Datapath of the file sync poll scheduler: configuration, subscription
// bits, stamps, scan pointer, walk and sweep logic, result registers.
// Depends on fsps_pkg; controlled by fsps_ctrl through ctl_t.
`timescale 1ns / 1ps
`default_nettype none

module fsps_dp
  import fsps_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_W-1:0]       cfg_wdata,
  input  wire  [2:0]             in_cmd,
  input  wire  [IDX_W-1:0]       in_file_index,
  input  wire  [1:0]             in_access_flags,
  input  wire  [TIME_W-1:0]      in_now_us,
  input  wire                    in_link_busy,
  input  ctl_t                   ctl,
  output sts_t                   sts,
  output logic                   out_status,
  output logic [1:0]             out_action,
  output logic [IDX_W-1:0]       out_action_file,
  output logic [MAX_FILES-1:0]   out_read_timeouts,
  output logic [MAX_FILES-1:0]   out_write_timeouts
);

  // configuration
  logic [DIR_W-1:0]  files_r;
  logic [TIME_W-1:0] tmo_r;

  // latched input beat
  cmd_t              cmd_r;
  logic [IDX_W-1:0]  file_r;
  logic [1:0]        flags_r;
  logic [TIME_W-1:0] now_r;
  logic              busy_r;

  // block state
  logic [MAX_FILES-1:0] rsub_r, wsub_r;
  logic [TIME_W-1:0]    rstamp_r [MAX_FILES];
  logic [TIME_W-1:0]    wstamp_r [MAX_FILES];
  logic [IDX_W-1:0]     ptr_r;
  logic                 rissued_r;
  logic [IDX_W-1:0]     cnt_r;

  // result under construction and result on the output
  logic                 res_status_r;
  act_t                 res_action_r;
  logic [IDX_W-1:0]     res_afile_r;
  logic [MAX_FILES-1:0] res_rmask_r, res_wmask_r;
  logic                 out_status_r;
  act_t                 out_action_r;
  logic [IDX_W-1:0]     out_afile_r;
  logic [MAX_FILES-1:0] out_rmask_r, out_wmask_r;

  logic [DIR_W-1:0]  dir_n;
  logic              ptr_in, hit_rd, hit_wr;
  logic [DIR_W-1:0]  ptr_inc, cnt_inc;
  logic [IDX_W-1:0]  ptr_next;
  logic              file_ok, flag_ok, is_add;
  logic [TIME_W-1:0] past, rage, wage;
  logic              rd_to, wr_to;

  // effective directory size: saturate, and zero counts as one
  always_comb begin
    if (files_r > DIR_W'(MAX_FILES)) dir_n = DIR_W'(MAX_FILES);
    else if (files_r == '0)           dir_n = DIR_W'(1);
    else                              dir_n = files_r;
  end

  // walk step at the scan pointer
  assign ptr_in   = {1'b0, ptr_r} < dir_n;
  assign ptr_inc  = {1'b0, ptr_r} + DIR_W'(1);
  assign ptr_next = (ptr_inc >= dir_n) ? '0 : ptr_inc[IDX_W-1:0];
  assign hit_rd   = !rissued_r && ptr_in && rsub_r[ptr_r];
  assign hit_wr   = ptr_in && wsub_r[ptr_r];

  // sweep step at the counter
  assign cnt_inc = {1'b0, cnt_r} + DIR_W'(1);
  assign past    = now_r - tmo_r;
  assign rage    = now_r - rstamp_r[cnt_r];
  assign wage    = now_r - wstamp_r[cnt_r];
  assign rd_to   = rage >= tmo_r;
  assign wr_to   = wage >= tmo_r;

  assign file_ok = {1'b0, file_r} < dir_n;
  assign flag_ok = |flags_r;
  assign is_add  = (cmd_r == CMD_ADD);

  always_comb begin
    sts.cmd        = cmd_r;
    sts.busy       = busy_r;
    sts.walk_last  = hit_rd || hit_wr || (ptr_next == '0);
    sts.sweep_last = cnt_inc >= dir_n;
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      files_r   <= FILES_RST;
      tmo_r     <= TIMEOUT_RST;
      rsub_r    <= '0;
      wsub_r    <= '0;
      ptr_r     <= '0;
      rissued_r <= 1'b0;
      cnt_r     <= '0;
      for (int i = 0; i < MAX_FILES; i++) begin
        rstamp_r[i] <= '0;
        wstamp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FILES_IN_USE) files_r <= cfg_wdata[DIR_W-1:0];
        else if (cfg_index == CFG_TIMEOUT_PERIOD) tmo_r <= cfg_wdata[TIME_W-1:0];
      end

      if (ctl.exec) begin
        cnt_r <= '0;
        unique case (cmd_r)
          CMD_ADD, CMD_REMOVE: begin
            if (file_ok) begin
              if (flags_r[0]) begin
                rsub_r[file_r] <= is_add;
                if (is_add) rstamp_r[file_r] <= now_r;
              end
              if (flags_r[1]) begin
                wsub_r[file_r] <= is_add;
                if (is_add) wstamp_r[file_r] <= now_r;
              end
            end
          end
          CMD_RD_END: rstamp_r[ptr_r] <= now_r;
          CMD_WR_END: wstamp_r[ptr_r] <= now_r;
          CMD_START:  ptr_r <= '0;
          default: ;
        endcase
      end

      if (ctl.walk_step) begin
        // read first, then write and advance
        priority if (hit_rd) begin
          rissued_r <= 1'b1;
        end else if (hit_wr) begin
          rissued_r <= 1'b0;
          ptr_r     <= ptr_next;
        end else begin
          ptr_r <= ptr_next;
        end
      end

      if (ctl.sweep_step) begin
        if (cmd_r == CMD_TICK) begin
          if (rd_to) rstamp_r[cnt_r] <= past;
          if (wr_to) wstamp_r[cnt_r] <= past;
        end else begin
          rstamp_r[cnt_r] <= now_r;
          wstamp_r[cnt_r] <= now_r;
        end
        cnt_r <= cnt_inc[IDX_W-1:0];
      end
    end
  end

  // payload: input latch, working result, output register
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r   <= cmd_t'(in_cmd);
      file_r  <= in_file_index;
      flags_r <= in_access_flags;
      now_r   <= in_now_us;
      busy_r  <= in_link_busy;
    end

    if (ctl.exec) begin
      res_status_r <= ((cmd_r == CMD_ADD) || (cmd_r == CMD_REMOVE)) &&
                      !(file_ok && flag_ok);
      res_action_r <= ACT_NONE;
      res_afile_r  <= '0;
      res_rmask_r  <= '0;
      res_wmask_r  <= '0;
    end

    if (ctl.walk_step && (hit_rd || hit_wr)) begin
      res_action_r <= hit_rd ? ACT_READ : ACT_WRITE;
      res_afile_r  <= ptr_r;
    end

    if (ctl.sweep_step && (cmd_r == CMD_TICK)) begin
      if (rd_to) res_rmask_r[cnt_r] <= 1'b1;
      if (wr_to) res_wmask_r[cnt_r] <= 1'b1;
    end

    if (ctl.load_out) begin
      out_status_r <= res_status_r;
      out_action_r <= res_action_r;
      out_afile_r  <= res_afile_r;
      out_rmask_r  <= res_rmask_r;
      out_wmask_r  <= res_wmask_r;
    end
  end

  assign out_status         = out_status_r;
  assign out_action         = out_action_r;
  assign out_action_file    = out_afile_r;
  assign out_read_timeouts  = out_rmask_r;
  assign out_write_timeouts = out_wmask_r;

endmodule

`default_nettype wire

// ===== rtl/file_sync_poll_scheduler.sv =====
// Top level of the file sync poll scheduler.
// Depends on fsps_pkg, fsps_ctrl and fsps_dp.
//
// One command beat in, one result beat out. Add and remove set or clear a
// file's read and write subscription bits (add also stamps them with
// now_us); a bad file index or empty flags returns status 1. Read end and
// write end stamp the file under the scan pointer. Idle, unless the link is
// busy, walks from the scan pointer toward the end of the directory one
// file per cycle and returns at most one remote read or remote write
// request. Tick checks every directory file, one per cycle, and reports
// the read and write stamps that have aged by timeout_period or more,
// rearming them to now minus the timeout. Start stamps every directory
// file and rewinds the pointer. Add, remove, read end, write end, a busy
// idle and the unused code go from decode straight to the result; idle
// walks first, and tick and start sweep first. The sweep uses the single
// sweep counter and the walk the single walk pointer, which visit one
// stamp pair or one subscription pair per cycle. in_ready is high only
// between items; a finished result sits in the output register, so the
// next beat is accepted and worked on while the previous result waits
// for out_ready. Write configuration only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module file_sync_poll_scheduler
  import fsps_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  // command channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [2:0]            in_cmd,
  input  wire  [IDX_W-1:0]      in_file_index,
  input  wire  [1:0]            in_access_flags,
  input  wire  [TIME_W-1:0]     in_now_us,
  input  wire                   in_link_busy,
  // result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_status,
  output logic [1:0]            out_action,
  output logic [IDX_W-1:0]      out_action_file,
  output logic [MAX_FILES-1:0]  out_read_timeouts,
  output logic [MAX_FILES-1:0]  out_write_timeouts,
  // configuration writes
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_W-1:0]      cfg_wdata
);

  ctl_t ctl;
  sts_t sts;

  // sequencing: accept, decode, walk or sweep, post the result
  fsps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // storage and per-step arithmetic
  fsps_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_cmd),
    .in_file_index      (in_file_index),
    .in_access_flags    (in_access_flags),
    .in_now_us          (in_now_us),
    .in_link_busy       (in_link_busy),
    .ctl                (ctl),
    .sts                (sts),
    .out_status         (out_status),
    .out_action         (out_action),
    .out_action_file    (out_action_file),
    .out_read_timeouts  (out_read_timeouts),
    .out_write_timeouts (out_write_timeouts)
  );

endmodule

`default_nettype wire

// ===== rtl/fsps_chk.sv =====
// Port-level checker for the file sync poll scheduler, with its bind.
// Depends on fsps_pkg; attaches to file_sync_poll_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module fsps_chk
  import fsps_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire                  out_status,
  input wire [1:0]            out_action,
  input wire [IDX_W-1:0]      out_action_file,
  input wire [MAX_FILES-1:0]  out_read_timeouts,
  input wire [MAX_FILES-1:0]  out_write_timeouts
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_action) && $stable(out_action_file) &&
    $stable(out_read_timeouts) && $stable(out_write_timeouts))
    else $error("result beat changed while stalled");

  // only the three action codes appear
  a_act_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_action == ACT_NONE) || (out_action == ACT_READ) ||
    (out_action == ACT_WRITE))
    else $error("unknown action code");

  // a requested transfer comes from idle only: ok status, no timeouts
  a_act_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_NONE) |-> !out_status &&
    (out_read_timeouts == '0) && (out_write_timeouts == '0))
    else $error("action mixed with other result fields");

  // an error carries nothing else
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_action == ACT_NONE) &&
    (out_action_file == '0) && (out_read_timeouts == '0) &&
    (out_write_timeouts == '0))
    else $error("error beat carries other fields");

endmodule

bind file_sync_poll_scheduler fsps_chk u_fsps_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_action         (out_action),
  .out_action_file    (out_action_file),
  .out_read_timeouts  (out_read_timeouts),
  .out_write_timeouts (out_write_timeouts)
);

`default_nettype wire
